>>> src/wspd_pkg.sv
// Shared types, constants and helper functions for the weather packet decoder.
package wspd_pkg;

  localparam int PACKET_BYTES = 32;
  localparam int POS_W        = $clog2(PACKET_BYTES);
  localparam int STORE_BYTES  = 28;
  localparam int STORE_IDX_W  = $clog2(STORE_BYTES);

  localparam logic [POS_W-1:0] LAST_POS      = POS_W'(PACKET_BYTES - 1);
  localparam logic [POS_W-1:0] SHORT_SUM_POS = POS_W'(27);
  localparam logic [POS_W-1:0] SHORT_SNAP_POS = POS_W'(26);

  localparam logic [7:0]  CRC_POLY     = 8'h31;
  localparam logic [7:0]  CRC_INIT     = 8'h00;
  localparam logic [7:0]  TYPE_LONG    = 8'h90;
  localparam logic [7:0]  TYPE_SHORT   = 8'h85;
  localparam logic [8:0]  WIND_INVALID = 9'h1FF;
  localparam logic [9:0]  TEMP_INVALID = 10'h3FF;
  localparam logic [7:0]  HUM_INVALID  = 8'hFF;
  localparam logic [5:0]  SUPERCAP_MASK = 6'h3F;
  localparam logic [12:0] BATT_MV_STEP  = 13'd20;
  localparam logic [12:0] BATT_MV_FLOOR = 13'd1400;
  localparam logic [6:0]  BATT_MAX      = 7'd100;

  typedef enum logic [1:0] {
    STATUS_LONG_OK      = 2'd0,
    STATUS_SHORT_OK     = 2'd1,
    STATUS_CHECK_FAIL   = 2'd2,
    STATUS_UNKNOWN_TYPE = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [23:0] device_id;
    logic [6:0]  battery_level;
    logic [9:0]  temperature_raw;
    logic [7:0]  relative_humidity;
    logic [8:0]  wind_speed_raw;
    logic [8:0]  wind_bearing;
    logic [8:0]  wind_gust_raw;
    logic [15:0] light_count;
    logic [15:0] rain_total;
    logic [7:0]  supercap_raw;
    logic [2:0]  valid_mask;
  } result_t;

  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [6:0] battery_of(input logic [7:0] b);
    logic [12:0] mv;
    logic [12:0] lvl;
    mv  = 13'(b) * BATT_MV_STEP;
    lvl = (mv - BATT_MV_FLOOR) >> 4;
    if (mv < BATT_MV_FLOOR) begin
      return '0;
    end else if (lvl > 13'(BATT_MAX)) begin
      return BATT_MAX;
    end else begin
      return lvl[6:0];
    end
  endfunction

endpackage

>>> src/wspd_if.sv
// Valid/ready channel interfaces for packet bytes and decoded results.
interface wspd_in_if;
  import wspd_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_start;

  modport source (output valid, data_byte, packet_start, input ready);
  modport sink   (input valid, data_byte, packet_start, output ready);
endinterface

interface wspd_out_if;
  import wspd_pkg::*;
  logic        valid;
  logic        ready;
  status_t     status;
  logic [23:0] device_id;
  logic [6:0]  battery_level;
  logic [9:0]  temperature_raw;
  logic [7:0]  relative_humidity;
  logic [8:0]  wind_speed_raw;
  logic [8:0]  wind_bearing;
  logic [8:0]  wind_gust_raw;
  logic [15:0] light_count;
  logic [15:0] rain_total;
  logic [7:0]  supercap_raw;
  logic [2:0]  valid_mask;

  modport source (output valid, status, device_id, battery_level, temperature_raw,
                  relative_humidity, wind_speed_raw, wind_bearing, wind_gust_raw,
                  light_count, rain_total, supercap_raw, valid_mask, input ready);
  modport sink   (input valid, status, device_id, battery_level, temperature_raw,
                  relative_humidity, wind_speed_raw, wind_bearing, wind_gust_raw,
                  light_count, rain_total, supercap_raw, valid_mask, output ready);
endinterface

>>> src/weather_sensor_packet_decoder.sv
// Weather packet decoder top level: CRC-8, byte sum, layout decode, result register.
//
//   channel   | dir | request                          | flow
//   in_chan   | in  | one packet byte, start-of-packet | valid/ready
//   out_chan  | out | status and decoded fields        | valid/ready
//
// Takes one byte per cycle while no result is held stalled; the result is valid in the cycle after byte 31 is taken.
// CRC fold and sum run combinationally from the state registers each cycle.
// Reset clears position, CRC, sum, snapshots and the result valid; the byte store is not reset.
// A stalled result holds in the output register; input stalls only when it is full and not taken.
module weather_sensor_packet_decoder (
  input  logic       clk,
  input  logic       rst_n,
  wspd_in_if.sink    in_chan,
  wspd_out_if.source out_chan
);
  import wspd_pkg::*;

  logic [POS_W-1:0] pos_r;
  logic [7:0]       crc_r;
  logic [7:0]       sum_r;
  logic [7:0]       crc_snap_r;
  logic [7:0]       sum_snap_r;
  logic [7:0]       pkt_r [STORE_BYTES];
  logic             out_valid_r;
  result_t          res_r;
  result_t          res_nxt;

  logic             accept;
  logic             last;
  logic [POS_W-1:0] cur_pos;
  logic [7:0]       crc_base;
  logic [7:0]       sum_base;
  logic [7:0]       crc_nxt;
  logic [7:0]       sum_nxt;
  logic [7:0]       flags;
  logic [8:0]       spd;
  logic [8:0]       dir;
  logic [8:0]       gst;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign cur_pos       = in_chan.packet_start ? '0 : pos_r;
  assign crc_base      = in_chan.packet_start ? CRC_INIT : crc_r;
  assign sum_base      = in_chan.packet_start ? '0 : sum_r;
  assign crc_nxt       = crc_fold(crc_base, in_chan.data_byte);
  assign sum_nxt       = sum_base + in_chan.data_byte;
  assign last          = (cur_pos == LAST_POS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      crc_r      <= CRC_INIT;
      sum_r      <= '0;
      crc_snap_r <= '0;
      sum_snap_r <= '0;
    end else if (accept) begin
      if (last) begin
        pos_r <= '0;
        crc_r <= crc_base;
        sum_r <= sum_base;
      end else begin
        pos_r <= cur_pos + 1'b1;
        crc_r <= crc_nxt;
        sum_r <= sum_nxt;
        if (cur_pos == SHORT_SNAP_POS) begin
          crc_snap_r <= crc_nxt;
          sum_snap_r <= sum_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (cur_pos < POS_W'(STORE_BYTES))) begin
      pkt_r[cur_pos[STORE_IDX_W-1:0]] <= in_chan.data_byte;
    end
  end

  always_comb begin
    res_nxt = '0;
    flags   = (pkt_r[0] == TYPE_LONG) ? pkt_r[7] : pkt_r[5];
    if (pkt_r[0] == TYPE_LONG) begin
      spd = {flags[4], pkt_r[10]};
      dir = {flags[5], pkt_r[11]};
      gst = {flags[6], pkt_r[12]};
    end else begin
      spd = {flags[4], pkt_r[7]};
      dir = {flags[5], pkt_r[8]};
      gst = {flags[6], pkt_r[9]};
    end
    if (pkt_r[0] == TYPE_LONG) begin
      if (crc_base != '0 || sum_base != in_chan.data_byte) begin
        res_nxt.status = STATUS_CHECK_FAIL;
      end else begin
        res_nxt.status            = STATUS_LONG_OK;
        res_nxt.device_id         = {pkt_r[1], pkt_r[2], pkt_r[3]};
        res_nxt.battery_level     = battery_of(pkt_r[6]);
        res_nxt.temperature_raw   = {flags[1:0], pkt_r[8]};
        res_nxt.relative_humidity = pkt_r[9];
        res_nxt.wind_speed_raw    = spd;
        res_nxt.wind_bearing      = dir;
        res_nxt.wind_gust_raw     = gst;
        res_nxt.light_count       = {pkt_r[4], pkt_r[5]};
        res_nxt.rain_total        = {pkt_r[19], pkt_r[20]};
        res_nxt.supercap_raw      = {2'b00, pkt_r[21][5:0] & SUPERCAP_MASK};
        res_nxt.valid_mask        = {spd != WIND_INVALID && dir != WIND_INVALID
                                       && gst != WIND_INVALID,
                                     pkt_r[9] != HUM_INVALID,
                                     {flags[1:0], pkt_r[8]} != TEMP_INVALID};
      end
    end else if (pkt_r[0] == TYPE_SHORT) begin
      if (crc_snap_r != '0 || sum_snap_r != pkt_r[SHORT_SUM_POS[STORE_IDX_W-1:0]]) begin
        res_nxt.status = STATUS_CHECK_FAIL;
      end else begin
        res_nxt.status         = STATUS_SHORT_OK;
        res_nxt.device_id      = {pkt_r[1], pkt_r[2], pkt_r[3]};
        res_nxt.battery_level  = battery_of(pkt_r[4]);
        res_nxt.wind_speed_raw = spd;
        res_nxt.wind_bearing   = dir;
        res_nxt.wind_gust_raw  = gst;
        res_nxt.supercap_raw   = pkt_r[6];
        res_nxt.valid_mask     = {spd != WIND_INVALID && dir != WIND_INVALID
                                    && gst != WIND_INVALID, 2'b00};
      end
    end else begin
      res_nxt.status = STATUS_UNKNOWN_TYPE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && last) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.status            = res_r.status;
  assign out_chan.device_id         = res_r.device_id;
  assign out_chan.battery_level     = res_r.battery_level;
  assign out_chan.temperature_raw   = res_r.temperature_raw;
  assign out_chan.relative_humidity = res_r.relative_humidity;
  assign out_chan.wind_speed_raw    = res_r.wind_speed_raw;
  assign out_chan.wind_bearing      = res_r.wind_bearing;
  assign out_chan.wind_gust_raw     = res_r.wind_gust_raw;
  assign out_chan.light_count       = res_r.light_count;
  assign out_chan.rain_total        = res_r.rain_total;
  assign out_chan.supercap_raw      = res_r.supercap_raw;
  assign out_chan.valid_mask        = res_r.valid_mask;

endmodule

>>> src/wspd_checker.sv
// Port-level assertions for the weather packet decoder, with its bind.
module wspd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input wspd_pkg::status_t   status,
  input logic [23:0]         device_id,
  input logic [6:0]          battery_level,
  input logic [9:0]          temperature_raw,
  input logic [7:0]          relative_humidity,
  input logic [15:0]         light_count,
  input logic [15:0]         rain_total,
  input logic [2:0]          valid_mask
);
  import wspd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(device_id))
    else $error("stalled result changed");

  a_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without an accepted byte");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STATUS_CHECK_FAIL || status == STATUS_UNKNOWN_TYPE)
      |-> device_id == '0 && battery_level == '0 && valid_mask == '0)
    else $error("failed packet carries field data");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STATUS_SHORT_OK
      |-> temperature_raw == '0 && relative_humidity == '0 && light_count == '0
          && rain_total == '0 && valid_mask[1:0] == 2'b00)
    else $error("short layout carries long-only fields");

  a_batt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> battery_level <= BATT_MAX)
    else $error("battery level above limit");

endmodule

bind weather_sensor_packet_decoder wspd_checker u_wspd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .status            (out_chan.status),
  .device_id         (out_chan.device_id),
  .battery_level     (out_chan.battery_level),
  .temperature_raw   (out_chan.temperature_raw),
  .relative_humidity (out_chan.relative_humidity),
  .light_count       (out_chan.light_count),
  .rain_total        (out_chan.rain_total),
  .valid_mask        (out_chan.valid_mask)
);
